FILE: sv/p2h_pkg.sv
// ----------------------------------------------------------------------------
// p2h_pkg: shared types and constants for the point-to-hex-cell pipeline
// fixed-point formats, stage payload structs, rounding and saturation helpers
// ----------------------------------------------------------------------------
package p2h_pkg;

    localparam int FRAC_BITS = 8;
    localparam int IN_W      = 24;
    localparam int CFG_W     = 24;
    localparam int OUT_W     = 16;
    localparam int K_W       = 20;
    localparam int MID_SHIFT = FRAC_BITS + 5;
    localparam int PREC      = 31;

    // sqrt3/3, 1/3, 2/3 in unsigned Q0.20
    localparam logic [K_W-1:0] K_SQ3_3 = 20'd605396;
    localparam logic [K_W-1:0] K_ONE_3 = 20'd349525;
    localparam logic [K_W-1:0] K_TWO_3 = 20'd699051;

    localparam int PROD_W = IN_W + K_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int NQ_W   = SUM_W - MID_SHIFT;
    localparam int F_W    = NQ_W + CFG_W + 1;
    localparam int FS_W   = F_W + 1;
    localparam int RND_W  = FS_W + 1 - PREC;
    localparam int E_W    = PREC;
    localparam int CELL_W = RND_W + 1;

    localparam logic [CFG_W-1:0] INV_RESET = CFG_W'(2048);
    localparam logic [PREC-1:0]  HALF      = {1'b1, {(PREC-1){1'b0}}};

    localparam logic signed [CELL_W-1:0] CELL_MAX = CELL_W'(32767);
    localparam logic signed [CELL_W-1:0] CELL_MIN = CELL_W'(-32768);
    localparam logic signed [OUT_W-1:0]  OUT_MAX  = OUT_W'(32767);
    localparam logic signed [OUT_W-1:0]  OUT_MIN  = OUT_W'(-32768);

    typedef struct packed {
        logic signed [PROD_W-1:0] pq_x;
        logic signed [PROD_W-1:0] pq_y;
        logic signed [PROD_W-1:0] pr_y;
    } t_prod;

    typedef struct packed {
        logic signed [NQ_W-1:0] nq;
        logic signed [NQ_W-1:0] nr;
    } t_mid;

    typedef struct packed {
        logic signed [F_W-1:0] fq;
        logic signed [F_W-1:0] fr;
    } t_frac;

    typedef struct packed {
        logic signed [FS_W-1:0] fq;
        logic signed [FS_W-1:0] fr;
        logic signed [FS_W-1:0] fs;
    } t_cube;

    typedef struct packed {
        logic signed [RND_W-1:0] rnd;
        logic [E_W-1:0]          err;
    } t_rnd;

    typedef struct packed {
        t_rnd q;
        t_rnd r;
        t_rnd s;
    } t_rcube;

    typedef struct packed {
        logic signed [OUT_W-1:0] val;
        logic                    clip;
    } t_sat;

    // floor(f + 1/2) and the exact distance between f and that integer
    function automatic t_rnd round_half_up(input logic signed [FS_W-1:0] f);
        logic signed [FS_W:0] t;
        logic [PREC-1:0]      m;
        t_rnd                 res;
        t = $signed({f[FS_W-1], f}) + $signed({{(FS_W+1-PREC){1'b0}}, HALF});
        m = t[PREC-1:0];
        res.rnd = t[FS_W:PREC];
        res.err = (m >= HALF) ? (m - HALF) : (HALF - m);
        return res;
    endfunction

    function automatic t_sat saturate(input logic signed [CELL_W-1:0] v);
        t_sat res;
        if (v > CELL_MAX) begin
            res.val  = OUT_MAX;
            res.clip = 1'b1;
        end else if (v < CELL_MIN) begin
            res.val  = OUT_MIN;
            res.clip = 1'b1;
        end else begin
            res.val  = v[OUT_W-1:0];
            res.clip = 1'b0;
        end
        return res;
    endfunction

endpackage

FILE: sv/p2h_front.sv
// ----------------------------------------------------------------------------
// p2h_front: point to unscaled fractional axial coordinates
// constant multiplies, then sum and floor to 15 fraction bits (two stages)
// ----------------------------------------------------------------------------
module p2h_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [p2h_pkg::IN_W-1:0]  i_x,
    input  logic signed [p2h_pkg::IN_W-1:0]  i_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output p2h_pkg::t_mid                    o_mid
);

    logic           r_v1;
    logic           r_v2;
    logic           w_rdy1;
    logic           w_rdy2;
    p2h_pkg::t_prod r_prod;
    p2h_pkg::t_prod n_prod;
    p2h_pkg::t_mid  r_mid;
    p2h_pkg::t_mid  n_mid;
    logic signed [p2h_pkg::SUM_W-1:0] w_sq;
    logic signed [p2h_pkg::SUM_W-1:0] w_sr;

    assign w_rdy2  = ~r_v2 | i_ready;
    assign w_rdy1  = ~r_v1 | w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_mid   = r_mid;

    always_comb begin
        n_prod.pq_x = p2h_pkg::PROD_W'(i_x * $signed({1'b0, p2h_pkg::K_SQ3_3}));
        n_prod.pq_y = p2h_pkg::PROD_W'(i_y * $signed({1'b0, p2h_pkg::K_ONE_3}));
        n_prod.pr_y = p2h_pkg::PROD_W'(i_y * $signed({1'b0, p2h_pkg::K_TWO_3}));
    end

    // taking the upper bits is the floor shift
    always_comb begin
        w_sq = p2h_pkg::SUM_W'(r_prod.pq_x) - p2h_pkg::SUM_W'(r_prod.pq_y);
        w_sr = p2h_pkg::SUM_W'(r_prod.pr_y);
        n_mid.nq = w_sq[p2h_pkg::SUM_W-1:p2h_pkg::MID_SHIFT];
        n_mid.nr = w_sr[p2h_pkg::SUM_W-1:p2h_pkg::MID_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy1) begin
            r_prod <= n_prod;
        end
        if (r_v1 && w_rdy2) begin
            r_mid <= n_mid;
        end
    end

endmodule

FILE: sv/p2h_scale.sv
// ----------------------------------------------------------------------------
// p2h_scale: scale by the cell-size reciprocal and form the third cube axis
// one multiply per axis, then s = -q - r (two stages)
// ----------------------------------------------------------------------------
module p2h_scale (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [p2h_pkg::CFG_W-1:0]        i_inv,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  p2h_pkg::t_mid                    i_mid,
    output logic                             o_valid,
    input  logic                             i_ready,
    output p2h_pkg::t_cube                   o_cube
);

    logic           r_v3;
    logic           r_v4;
    logic           w_rdy3;
    logic           w_rdy4;
    p2h_pkg::t_frac r_frac;
    p2h_pkg::t_frac n_frac;
    p2h_pkg::t_cube r_cube;
    p2h_pkg::t_cube n_cube;
    logic signed [p2h_pkg::CFG_W:0] w_inv_s;

    assign w_rdy4  = ~r_v4 | i_ready;
    assign w_rdy3  = ~r_v3 | w_rdy4;
    assign o_ready = w_rdy3;
    assign o_valid = r_v4;
    assign o_cube  = r_cube;
    assign w_inv_s = $signed({1'b0, i_inv});

    always_comb begin
        n_frac.fq = p2h_pkg::F_W'(i_mid.nq * w_inv_s);
        n_frac.fr = p2h_pkg::F_W'(i_mid.nr * w_inv_s);
    end

    always_comb begin
        n_cube.fq = p2h_pkg::FS_W'(r_frac.fq);
        n_cube.fr = p2h_pkg::FS_W'(r_frac.fr);
        n_cube.fs = -p2h_pkg::FS_W'(r_frac.fq) - p2h_pkg::FS_W'(r_frac.fr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy3) begin
                r_v3 <= i_valid;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy3) begin
            r_frac <= n_frac;
        end
        if (r_v3 && w_rdy4) begin
            r_cube <= n_cube;
        end
    end

endmodule

FILE: sv/p2h_round.sv
// ----------------------------------------------------------------------------
// p2h_round: cube rounding, rebuild of the worst axis and saturation
// rounds and errors in one stage, select and clamp into the output register
// ----------------------------------------------------------------------------
module p2h_round (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  p2h_pkg::t_cube                   i_cube,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [p2h_pkg::OUT_W-1:0] o_q,
    output logic signed [p2h_pkg::OUT_W-1:0] o_r,
    output logic                             o_clip
);

    logic             r_v5;
    logic             r_v6;
    logic             w_rdy5;
    logic             w_rdy6;
    p2h_pkg::t_rcube  r_rc;
    p2h_pkg::t_rcube  n_rc;
    logic signed [p2h_pkg::CELL_W-1:0] w_cq;
    logic signed [p2h_pkg::CELL_W-1:0] w_cr;
    p2h_pkg::t_sat    w_sq;
    p2h_pkg::t_sat    w_sr;
    logic signed [p2h_pkg::OUT_W-1:0] r_q;
    logic signed [p2h_pkg::OUT_W-1:0] r_r;
    logic             r_clip;

    assign w_rdy6  = ~r_v6 | i_ready;
    assign w_rdy5  = ~r_v5 | w_rdy6;
    assign o_ready = w_rdy5;
    assign o_valid = r_v6;
    assign o_q     = r_q;
    assign o_r     = r_r;
    assign o_clip  = r_clip;

    always_comb begin
        n_rc.q = p2h_pkg::round_half_up(i_cube.fq);
        n_rc.r = p2h_pkg::round_half_up(i_cube.fr);
        n_rc.s = p2h_pkg::round_half_up(i_cube.fs);
    end

    // strict compares: on ties q is kept first, then r
    always_comb begin
        w_cq = p2h_pkg::CELL_W'(r_rc.q.rnd);
        w_cr = p2h_pkg::CELL_W'(r_rc.r.rnd);
        if (r_rc.q.err > r_rc.r.err && r_rc.q.err > r_rc.s.err) begin
            w_cq = -p2h_pkg::CELL_W'(r_rc.r.rnd) - p2h_pkg::CELL_W'(r_rc.s.rnd);
        end else if (r_rc.r.err > r_rc.s.err) begin
            w_cr = -p2h_pkg::CELL_W'(r_rc.q.rnd) - p2h_pkg::CELL_W'(r_rc.s.rnd);
        end
        w_sq = p2h_pkg::saturate(w_cq);
        w_sr = p2h_pkg::saturate(w_cr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy5) begin
                r_v5 <= i_valid;
            end
            if (w_rdy6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy5) begin
            r_rc <= n_rc;
        end
        if (r_v5 && w_rdy6) begin
            r_q    <= w_sq.val;
            r_r    <= w_sr.val;
            r_clip <= w_sq.clip | w_sr.clip;
        end
    end

endmodule

FILE: sv/point_to_hex_cell.sv
// ----------------------------------------------------------------------------
// point_to_hex_cell: axial cell of a pointy-top hex grid for a fixed-point point
// six-stage pipeline with cube rounding and 16-bit saturation
// ----------------------------------------------------------------------------
// Usage:
//   point request: i_point_valid / o_point_ready with i_point_x, i_point_y
//   (signed Q15.8). cell request: o_cell_valid / i_cell_ready with o_cell_q,
//   o_cell_r (axial, signed 16-bit) and o_clipped (either one saturated).
//   i_inv_cell_size_we writes i_inv_cell_size (unsigned Q8.16 reciprocal of
//   the cell size) at the clock edge; write it only while the pipe is empty.
// Pipeline: six register stages: constant products, sum and floor,
//   reciprocal multiply, third axis, rounding, select/clamp.
// Throughput: one point per cycle while i_cell_ready does not stall the
//   output; each multiply stage has its own multipliers.
// Reset: synchronous, active low; all stage valid bits clear and the
//   reciprocal returns to 2048 (cell size 32).
// Stall: each stage holds while its successor is full and stalled; bubbles
//   still close up, so requests are taken until all six stages are full.
// ----------------------------------------------------------------------------
module point_to_hex_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_inv_cell_size_we,
    input  logic [p2h_pkg::CFG_W-1:0]        i_inv_cell_size,
    input  logic                             i_point_valid,
    output logic                             o_point_ready,
    input  logic signed [p2h_pkg::IN_W-1:0]  i_point_x,
    input  logic signed [p2h_pkg::IN_W-1:0]  i_point_y,
    output logic                             o_cell_valid,
    input  logic                             i_cell_ready,
    output logic signed [p2h_pkg::OUT_W-1:0] o_cell_q,
    output logic signed [p2h_pkg::OUT_W-1:0] o_cell_r,
    output logic                             o_clipped
);

    logic [p2h_pkg::CFG_W-1:0] r_inv_cell_size;
    logic                      w_mid_valid;
    logic                      w_mid_ready;
    p2h_pkg::t_mid             w_mid;
    logic                      w_cube_valid;
    logic                      w_cube_ready;
    p2h_pkg::t_cube            w_cube;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cell_size <= p2h_pkg::INV_RESET;
        end else if (i_inv_cell_size_we) begin
            r_inv_cell_size <= i_inv_cell_size;
        end
    end

    p2h_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_point_valid),
        .o_ready (o_point_ready),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_mid   (w_mid)
    );

    p2h_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inv   (r_inv_cell_size),
        .i_valid (w_mid_valid),
        .o_ready (w_mid_ready),
        .i_mid   (w_mid),
        .o_valid (w_cube_valid),
        .i_ready (w_cube_ready),
        .o_cube  (w_cube)
    );

    p2h_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cube_valid),
        .o_ready (w_cube_ready),
        .i_cube  (w_cube),
        .o_valid (o_cell_valid),
        .i_ready (i_cell_ready),
        .o_q     (o_cell_q),
        .o_r     (o_cell_r),
        .o_clip  (o_clipped)
    );

`ifndef SYNTHESIS
    // the input side only blocks when the whole pipe is backed up to the output
    a_ready_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_point_ready |-> (o_cell_valid && !i_cell_ready))
        else $error("input stalled while output is free");

    a_clip_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_valid && o_clipped) |->
            (o_cell_q == p2h_pkg::OUT_MAX || o_cell_q == p2h_pkg::OUT_MIN ||
             o_cell_r == p2h_pkg::OUT_MAX || o_cell_r == p2h_pkg::OUT_MIN))
        else $error("clipped flag without a saturated coordinate");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_cell_valid)
        else $error("cell request valid right after reset");
`endif

endmodule
